>>> sv/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Widths and types shared by the segment/segment intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // Coordinate width of every input and output coordinate
    localparam int COORD_WIDTH = 32;
    // Coordinate difference, one bit wider than a coordinate
    localparam int DIFF_W      = COORD_WIDTH + 1;
    // Product of two differences
    localparam int PROD_W      = 2 * DIFF_W;
    // Cross product (difference of two products)
    localparam int CROSS_W     = PROD_W + 1;
    // Magnitude of a cross product
    localparam int MAG_W       = CROSS_W - 1;
    // Magnitude of |t_numer| * |dir|
    localparam int NUM_W       = MAG_W + COORD_WIDTH;
    // Upper part of |t_numer| multiplied separately
    localparam int HI_W        = MAG_W - COORD_WIDTH;

    // Front stages before the divider, then one divider stage per quotient bit,
    // then the output stage
    localparam int FRONT_STAGES = 6;
    localparam int NUM_STAGES   = FRONT_STAGES + COORD_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [COORD_WIDTH-1:0] quo_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;
    typedef logic        [MAG_W-1:0]       mag_t;
    typedef logic        [NUM_W-1:0]       num_t;
    typedef logic        [HI_W-1:0]        hi_t;

endpackage

>>> sv/ssi_if.sv
// ----------------------------------------------------------------------------
// ssi_if
// Valid/ready channels for segment pairs and intersection results.
// ----------------------------------------------------------------------------
interface ssi_in_if;
    logic            valid;
    logic            ready;
    ssi_pkg::coord_t seg_a_start_x;
    ssi_pkg::coord_t seg_a_start_y;
    ssi_pkg::coord_t seg_a_end_x;
    ssi_pkg::coord_t seg_a_end_y;
    ssi_pkg::coord_t seg_b_start_x;
    ssi_pkg::coord_t seg_b_start_y;
    ssi_pkg::coord_t seg_b_end_x;
    ssi_pkg::coord_t seg_b_end_y;

    modport source
    (
        output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
               seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
        input  ready
    );

    modport sink
    (
        input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
               seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
        output ready
    );
endinterface

interface ssi_out_if;
    logic            valid;
    logic            ready;
    logic            hit;
    ssi_pkg::coord_t cross_x;
    ssi_pkg::coord_t cross_y;

    modport source
    (
        output valid, hit, cross_x, cross_y,
        input  ready
    );

    modport sink
    (
        input  valid, hit, cross_x, cross_y,
        output ready
    );
endinterface

>>> sv/ssi_div_stage.sv
// ----------------------------------------------------------------------------
// ssi_div_stage
// One registered restoring-division step: shifts in the next numerator bit,
// subtracts the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module ssi_div_stage
(
    input  logic          clk,
    input  logic          load,
    input  ssi_pkg::mag_t den,
    input  ssi_pkg::mag_t rem_in,
    input  ssi_pkg::quo_t low_in,
    output ssi_pkg::mag_t rem,
    output ssi_pkg::quo_t low
);
    import ssi_pkg::*;

    logic [MAG_W:0] trial;
    logic           fits;
    mag_t           rem_reg;
    mag_t           rem_next;
    quo_t           low_reg;
    quo_t           low_next;

    // Form the trial remainder and take the divisor out when it fits
    always_comb
    begin
        trial    = {rem_in, low_in[COORD_WIDTH-1]};
        fits     = (trial >= {1'b0, den});
        rem_next = fits ? MAG_W'(trial - {1'b0, den}) : trial[MAG_W-1:0];
        low_next = {low_in[COORD_WIDTH-2:0], fits};
    end

    // Hold the step result until the stage advances
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign rem = rem_reg;
    assign low = low_reg;

endmodule

>>> sv/segment_segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_segment_intersection
// Exact 2D segment/segment intersection with the crossing point.
//
//   channel | dir | transaction
//   --------+-----+-------------------------------------------------
//   req     | in  | two segments A and B, eight signed coordinates
//   rsp     | out | hit flag and crossing point (zeros on a miss)
//
// One transaction per cycle is accepted while the pipeline is not stalled; each
// result passes through six front stages (differences, products, cross
// products, magnitudes and tests, partial products, numerator sum), one
// restoring-division stage per quotient bit, and the output register.
// Reset clears only the valid bits. Each stage advances when it is empty or
// the stage after it advances, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
module segment_segment_intersection
(
    input  logic      clk,
    input  logic      rst_n,
    ssi_in_if.sink    req,
    ssi_out_if.source rsp
);
    import ssi_pkg::*;

    localparam int DIV0 = FRONT_STAGES;
    localparam int LAST = NUM_STAGES - 1;

    // Stage valid bits and advance enables
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] adv;

    // Stage 1: differences and box test
    diff_t  dax_reg, day_reg, dbx_reg, dby_reg, ox_reg, oy_reg;
    coord_t ax0_s1_reg, ay0_s1_reg;
    logic   miss_s1_reg;
    logic   miss_next;

    // Stage 2: products
    prod_t  p_den1_reg, p_den2_reg, p_sn1_reg, p_sn2_reg, p_tn1_reg, p_tn2_reg;
    diff_t  dax_s2_reg, day_s2_reg;
    coord_t ax0_s2_reg, ay0_s2_reg;
    logic   miss_s2_reg;

    // Stage 3: cross products
    cross_t den_reg, sn_reg, tn_reg;
    diff_t  dax_s3_reg, day_s3_reg;
    coord_t ax0_s3_reg, ay0_s3_reg;
    logic   miss_s3_reg;

    // Stage 4: signs and magnitudes
    mag_t   den_abs_s4_reg, sn_abs_reg, tn_abs_s4_reg;
    quo_t   dax_abs_s4_reg, day_abs_s4_reg;
    logic   den_neg_reg, den_zero_reg, sn_neg_reg, tn_neg_reg;
    logic   qneg_x_s4_reg, qneg_y_s4_reg;
    coord_t ax0_s4_reg, ay0_s4_reg;
    logic   miss_s4_reg;
    cross_t den_abs_next, sn_abs_next, tn_abs_next;
    diff_t  dax_abs_next, day_abs_next;

    // Stage 5: hit decision and partial products
    logic [2*COORD_WIDTH-1:0]    ppx_lo_reg, ppy_lo_reg;
    logic [HI_W+COORD_WIDTH-1:0] ppx_hi_reg, ppy_hi_reg;
    mag_t   den_abs_s5_reg;
    logic   hit_s5_reg, qneg_x_s5_reg, qneg_y_s5_reg;
    coord_t ax0_s5_reg, ay0_s5_reg;
    logic   den_pos;

    // Stage 6: full numerators
    num_t   nx_reg, ny_reg;
    mag_t   den_abs_s6_reg;
    logic   hit_s6_reg, qneg_x_s6_reg, qneg_y_s6_reg;
    coord_t ax0_s6_reg, ay0_s6_reg;

    // Divider side data, one entry per division stage
    mag_t   dv_den_reg   [COORD_WIDTH];
    logic   dv_hit_reg   [COORD_WIDTH];
    logic   dv_qneg_x_reg[COORD_WIDTH];
    logic   dv_qneg_y_reg[COORD_WIDTH];
    coord_t dv_ax0_reg   [COORD_WIDTH];
    coord_t dv_ay0_reg   [COORD_WIDTH];
    mag_t   dvx_rem      [COORD_WIDTH];
    mag_t   dvy_rem      [COORD_WIDTH];
    quo_t   dvx_low      [COORD_WIDTH];
    quo_t   dvy_low      [COORD_WIDTH];

    // Output register
    logic   hit_reg;
    coord_t cross_x_reg, cross_y_reg;
    quo_t   qx, qy;

    // Advance chain: a stage loads when empty or when its contents move on
    always_comb
    begin
        adv[LAST] = !v_reg[LAST] || rsp.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign req.ready = adv[0];

    // Move the valid bits along
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= req.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Reject when one box lies wholly beside the other
    always_comb
    begin
        miss_next =
            (req.seg_a_start_x < req.seg_b_start_x && req.seg_a_start_x < req.seg_b_end_x &&
             req.seg_a_end_x   < req.seg_b_start_x && req.seg_a_end_x   < req.seg_b_end_x) ||
            (req.seg_b_start_x < req.seg_a_start_x && req.seg_b_start_x < req.seg_a_end_x &&
             req.seg_b_end_x   < req.seg_a_start_x && req.seg_b_end_x   < req.seg_a_end_x) ||
            (req.seg_a_start_y < req.seg_b_start_y && req.seg_a_start_y < req.seg_b_end_y &&
             req.seg_a_end_y   < req.seg_b_start_y && req.seg_a_end_y   < req.seg_b_end_y) ||
            (req.seg_b_start_y < req.seg_a_start_y && req.seg_b_start_y < req.seg_a_end_y &&
             req.seg_b_end_y   < req.seg_a_start_y && req.seg_b_end_y   < req.seg_a_end_y);
    end

    // Stage 1: take the differences
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dax_reg     <= diff_t'(req.seg_a_end_x) - diff_t'(req.seg_a_start_x);
            day_reg     <= diff_t'(req.seg_a_end_y) - diff_t'(req.seg_a_start_y);
            dbx_reg     <= diff_t'(req.seg_b_end_x) - diff_t'(req.seg_b_start_x);
            dby_reg     <= diff_t'(req.seg_b_end_y) - diff_t'(req.seg_b_start_y);
            ox_reg      <= diff_t'(req.seg_a_start_x) - diff_t'(req.seg_b_start_x);
            oy_reg      <= diff_t'(req.seg_a_start_y) - diff_t'(req.seg_b_start_y);
            ax0_s1_reg  <= req.seg_a_start_x;
            ay0_s1_reg  <= req.seg_a_start_y;
            miss_s1_reg <= miss_next;
        end
    end

    // Stage 2: multiply the cross-product terms
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            p_den1_reg  <= prod_t'(dax_reg) * prod_t'(dby_reg);
            p_den2_reg  <= prod_t'(day_reg) * prod_t'(dbx_reg);
            p_sn1_reg   <= prod_t'(dax_reg) * prod_t'(oy_reg);
            p_sn2_reg   <= prod_t'(day_reg) * prod_t'(ox_reg);
            p_tn1_reg   <= prod_t'(dbx_reg) * prod_t'(oy_reg);
            p_tn2_reg   <= prod_t'(dby_reg) * prod_t'(ox_reg);
            dax_s2_reg  <= dax_reg;
            day_s2_reg  <= day_reg;
            ax0_s2_reg  <= ax0_s1_reg;
            ay0_s2_reg  <= ay0_s1_reg;
            miss_s2_reg <= miss_s1_reg;
        end
    end

    // Stage 3: subtract to form denom and both numerators
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            den_reg     <= cross_t'(p_den1_reg) - cross_t'(p_den2_reg);
            sn_reg      <= cross_t'(p_sn1_reg) - cross_t'(p_sn2_reg);
            tn_reg      <= cross_t'(p_tn1_reg) - cross_t'(p_tn2_reg);
            dax_s3_reg  <= dax_s2_reg;
            day_s3_reg  <= day_s2_reg;
            ax0_s3_reg  <= ax0_s2_reg;
            ay0_s3_reg  <= ay0_s2_reg;
            miss_s3_reg <= miss_s2_reg;
        end
    end

    // Stage 4: split into sign and magnitude
    always_comb
    begin
        den_abs_next = den_reg[CROSS_W-1] ? -den_reg : den_reg;
        sn_abs_next  = sn_reg[CROSS_W-1] ? -sn_reg : sn_reg;
        tn_abs_next  = tn_reg[CROSS_W-1] ? -tn_reg : tn_reg;
        dax_abs_next = dax_s3_reg[DIFF_W-1] ? -dax_s3_reg : dax_s3_reg;
        day_abs_next = day_s3_reg[DIFF_W-1] ? -day_s3_reg : day_s3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            den_abs_s4_reg <= den_abs_next[MAG_W-1:0];
            sn_abs_reg     <= sn_abs_next[MAG_W-1:0];
            tn_abs_s4_reg  <= tn_abs_next[MAG_W-1:0];
            dax_abs_s4_reg <= dax_abs_next[COORD_WIDTH-1:0];
            day_abs_s4_reg <= day_abs_next[COORD_WIDTH-1:0];
            den_neg_reg    <= den_reg[CROSS_W-1];
            den_zero_reg   <= (den_reg == '0);
            sn_neg_reg     <= sn_reg[CROSS_W-1];
            tn_neg_reg     <= tn_reg[CROSS_W-1];
            qneg_x_s4_reg  <= tn_reg[CROSS_W-1] ^ dax_s3_reg[DIFF_W-1] ^ den_reg[CROSS_W-1];
            qneg_y_s4_reg  <= tn_reg[CROSS_W-1] ^ day_s3_reg[DIFF_W-1] ^ den_reg[CROSS_W-1];
            ax0_s4_reg     <= ax0_s3_reg;
            ay0_s4_reg     <= ay0_s3_reg;
            miss_s4_reg    <= miss_s3_reg;
        end
    end

    // Stage 5: decide the hit and start |t_numer| * |dir|
    assign den_pos = !den_neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            hit_s5_reg     <= !miss_s4_reg && !den_zero_reg &&
                              (sn_neg_reg != den_pos) && (tn_neg_reg != den_pos) &&
                              (sn_abs_reg <= den_abs_s4_reg) &&
                              (tn_abs_s4_reg <= den_abs_s4_reg);
            ppx_lo_reg     <= (2*COORD_WIDTH)'(tn_abs_s4_reg[COORD_WIDTH-1:0]) *
                              (2*COORD_WIDTH)'(dax_abs_s4_reg);
            ppy_lo_reg     <= (2*COORD_WIDTH)'(tn_abs_s4_reg[COORD_WIDTH-1:0]) *
                              (2*COORD_WIDTH)'(day_abs_s4_reg);
            ppx_hi_reg     <= (HI_W+COORD_WIDTH)'(tn_abs_s4_reg[MAG_W-1:COORD_WIDTH]) *
                              (HI_W+COORD_WIDTH)'(dax_abs_s4_reg);
            ppy_hi_reg     <= (HI_W+COORD_WIDTH)'(tn_abs_s4_reg[MAG_W-1:COORD_WIDTH]) *
                              (HI_W+COORD_WIDTH)'(day_abs_s4_reg);
            den_abs_s5_reg <= den_abs_s4_reg;
            qneg_x_s5_reg  <= qneg_x_s4_reg;
            qneg_y_s5_reg  <= qneg_y_s4_reg;
            ax0_s5_reg     <= ax0_s4_reg;
            ay0_s5_reg     <= ay0_s4_reg;
        end
    end

    // Stage 6: add the partial products
    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            nx_reg         <= NUM_W'(ppx_lo_reg) + {ppx_hi_reg, {COORD_WIDTH{1'b0}}};
            ny_reg         <= NUM_W'(ppy_lo_reg) + {ppy_hi_reg, {COORD_WIDTH{1'b0}}};
            den_abs_s6_reg <= den_abs_s5_reg;
            hit_s6_reg     <= hit_s5_reg;
            qneg_x_s6_reg  <= qneg_x_s5_reg;
            qneg_y_s6_reg  <= qneg_y_s5_reg;
            ax0_s6_reg     <= ax0_s5_reg;
            ay0_s6_reg     <= ay0_s5_reg;
        end
    end

    // Division stages: one quotient bit each, side data follows along
    for (genvar k = 0; k < COORD_WIDTH; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            ssi_div_stage u_div_x
            (
                .clk    (clk),
                .load   (adv[DIV0]),
                .den    (den_abs_s6_reg),
                .rem_in (nx_reg[NUM_W-1:COORD_WIDTH]),
                .low_in (nx_reg[COORD_WIDTH-1:0]),
                .rem    (dvx_rem[k]),
                .low    (dvx_low[k])
            );

            ssi_div_stage u_div_y
            (
                .clk    (clk),
                .load   (adv[DIV0]),
                .den    (den_abs_s6_reg),
                .rem_in (ny_reg[NUM_W-1:COORD_WIDTH]),
                .low_in (ny_reg[COORD_WIDTH-1:0]),
                .rem    (dvy_rem[k]),
                .low    (dvy_low[k])
            );

            always_ff @(posedge clk)
            begin
                if (adv[DIV0])
                begin
                    dv_den_reg[k]    <= den_abs_s6_reg;
                    dv_hit_reg[k]    <= hit_s6_reg;
                    dv_qneg_x_reg[k] <= qneg_x_s6_reg;
                    dv_qneg_y_reg[k] <= qneg_y_s6_reg;
                    dv_ax0_reg[k]    <= ax0_s6_reg;
                    dv_ay0_reg[k]    <= ay0_s6_reg;
                end
            end
        end
        else
        begin : g_next
            ssi_div_stage u_div_x
            (
                .clk    (clk),
                .load   (adv[DIV0+k]),
                .den    (dv_den_reg[k-1]),
                .rem_in (dvx_rem[k-1]),
                .low_in (dvx_low[k-1]),
                .rem    (dvx_rem[k]),
                .low    (dvx_low[k])
            );

            ssi_div_stage u_div_y
            (
                .clk    (clk),
                .load   (adv[DIV0+k]),
                .den    (dv_den_reg[k-1]),
                .rem_in (dvy_rem[k-1]),
                .low_in (dvy_low[k-1]),
                .rem    (dvy_rem[k]),
                .low    (dvy_low[k])
            );

            always_ff @(posedge clk)
            begin
                if (adv[DIV0+k])
                begin
                    dv_den_reg[k]    <= dv_den_reg[k-1];
                    dv_hit_reg[k]    <= dv_hit_reg[k-1];
                    dv_qneg_x_reg[k] <= dv_qneg_x_reg[k-1];
                    dv_qneg_y_reg[k] <= dv_qneg_y_reg[k-1];
                    dv_ax0_reg[k]    <= dv_ax0_reg[k-1];
                    dv_ay0_reg[k]    <= dv_ay0_reg[k-1];
                end
            end
        end
    end

    // Output stage: apply the quotient sign and offset from A's start
    assign qx = dvx_low[COORD_WIDTH-1];
    assign qy = dvy_low[COORD_WIDTH-1];

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            hit_reg <= dv_hit_reg[COORD_WIDTH-1];
            if (dv_hit_reg[COORD_WIDTH-1])
            begin
                cross_x_reg <= dv_qneg_x_reg[COORD_WIDTH-1] ?
                               coord_t'(dv_ax0_reg[COORD_WIDTH-1] - qx) :
                               coord_t'(dv_ax0_reg[COORD_WIDTH-1] + qx);
                cross_y_reg <= dv_qneg_y_reg[COORD_WIDTH-1] ?
                               coord_t'(dv_ay0_reg[COORD_WIDTH-1] - qy) :
                               coord_t'(dv_ay0_reg[COORD_WIDTH-1] + qy);
            end
            else
            begin
                cross_x_reg <= '0;
                cross_y_reg <= '0;
            end
        end
    end

    assign rsp.valid   = v_reg[LAST];
    assign rsp.hit     = hit_reg;
    assign rsp.cross_x = cross_x_reg;
    assign rsp.cross_y = cross_y_reg;

endmodule
